// ===== hw/rtl/ssort_pkg.sv =====
// shared types, constants and helpers for the stable insertion sorter
package ssort_pkg;

  localparam int DataW        = 32;
  localparam int DefaultDepth = 16;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // insert the incoming sample
    logic drain;  // shift contents one cell towards the head
  } cell_ctrl_t;

  // signed less-than on two's complement words
  function automatic logic less_signed(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== hw/rtl/ssort_cell.sv =====
// one cell of the sorting chain: holds a value and trades it with its neighbours
module ssort_cell (
  input  logic                       clk_i,
  input  ssort_pkg::cell_ctrl_t      ctrl_i,
  input  logic [ssort_pkg::DataW-1:0] sample_i,
  input  logic                       occupied_i,
  input  logic                       left_take_i,
  input  logic [ssort_pkg::DataW-1:0] left_value_i,
  input  logic [ssort_pkg::DataW-1:0] right_value_i,
  output logic                       take_o,
  output logic [ssort_pkg::DataW-1:0] value_o
);
  import ssort_pkg::*;

  logic [DataW-1:0] value_q, value_d;

  // strict compare keeps equal values in arrival order
  assign take_o  = !occupied_i || less_signed(sample_i, value_q);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && take_o) begin
      value_d = left_take_i ? left_value_i : sample_i;
    end else if (ctrl_i.drain) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== hw/rtl/stable_insertion_sorter.sv =====
// stable ascending insertion sorter built from a chain of compare-and-shift cells
// collecting: one sample per cycle, every cell compares and shifts in the same cycle
// read-out: the end-of-set transfer starts read-out; results are registered from the head of the
//   chain, one result per cycle while the output is not stalled; input is stalled until the last
//   result has left the chain
// reset clears count, overflow flag, read-out state and output valid; cell contents are not reset
module stable_insertion_sorter #(
  parameter int DEPTH = ssort_pkg::DefaultDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ssort_pkg::DataW-1:0] sample_value_i,
  input  logic                              end_of_set_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ssort_pkg::DataW-1:0] sorted_value_o,
  output logic                              final_result_o,
  output logic                              overflowed_o
);
  import ssort_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // control state
  logic [CntW-1:0] count_q, count_d;
  logic            drain_q, drain_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;

  // output payload register
  logic [DataW-1:0] out_value_q;
  logic             out_final_q;
  logic             out_ovf_q;

  logic       in_xfer;
  logic       full;
  logic       pop;
  cell_ctrl_t ctrl;

  logic [DEPTH-1:0]            occupied;
  logic [DEPTH-1:0]            take;
  logic [DEPTH-1:0][DataW-1:0] value;

  // no new samples while the set is being read out
  assign in_stall_o = drain_q;
  assign in_xfer    = in_valid_i && !drain_q;
  assign full       = (count_q == CntW'(DEPTH));

  // during read-out, pull the head of the chain into the output register whenever that register frees up
  assign pop = drain_q && (!out_valid_q || !out_stall_i);

  assign ctrl.ins   = in_xfer && !full;
  assign ctrl.drain = pop;

  // cells below the fill count hold live values
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occupied[i] = (CntW'(i) < count_q);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic             left_take;
    logic [DataW-1:0] left_value;
    logic [DataW-1:0] right_value;

    if (g == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_value = '0;
    end else begin : g_body
      assign left_take  = take[g-1];
      assign left_value = value[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = value[g+1];
    end

    ssort_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .sample_i      (sample_value_i),
      .occupied_i    (occupied[g]),
      .left_take_i   (left_take),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .take_o        (take[g]),
      .value_o       (value[g])
    );
  end

  always_comb begin
    count_d     = count_q;
    drain_d     = drain_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;

    if (in_xfer) begin
      // a sample arriving at a full chain is dropped and flagged
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
      if (end_of_set_i) begin
        drain_d = 1'b1;
      end
    end

    if (pop) begin
      count_d = count_q - CntW'(1);
      // last value of the set leaves: back to collecting
      if (count_q == CntW'(1)) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end

    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_value_q <= value[0];
      out_final_q <= (count_q == CntW'(1));
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_result_o = out_final_q;
  assign overflowed_o   = out_ovf_q;

endmodule

// ===== tb/sv/stable_insertion_sorter_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the stable insertion sorter: random sets, bursty handshakes
module stable_insertion_sorter_tb;

  localparam int SortDepth   = ssort_pkg::DefaultDepth;
  localparam int ValueW      = ssort_pkg::DataW;
  localparam int RandomItems = 320;
  localparam int QuietItems  = 40;       // tail of the run with no idling on either side
  localparam int HoldOffAt   = 120;      // accepted items before the long receiver hold-off
  localparam int HoldOffLen  = 200;
  localparam int CycleLimit  = 200000;

  localparam logic signed [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] MaxValue = {1'b0, {(ValueW-1){1'b1}}};

  // one input transfer
  typedef struct {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } sample_item_t;

  // one result transfer
  typedef struct {
    logic signed [ValueW-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_item_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic signed [ValueW-1:0] sample_value_i = '0;
  logic                     end_of_set_i   = 1'b0;
  logic                     out_stall_i    = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [ValueW-1:0] sorted_value_o;
  logic                     final_result_o;
  logic                     overflowed_o;

  stable_insertion_sorter #(
    .DEPTH(SortDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_value_i(sample_value_i),
    .end_of_set_i  (end_of_set_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .final_result_o(final_result_o),
    .overflowed_o  (overflowed_o)
  );

  // a transfer happens at a rising edge with valid high and stall low
  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_xfer = out_valid_o && !out_stall_i;

  sample_item_t samples_pending[$];   // stimulus not yet offered
  sorted_item_t sorted_due[$];        // predicted results, oldest first

  // shadow of the sorter state
  logic signed [ValueW-1:0] shadow_store [SortDepth];
  int unsigned              shadow_count    = 0;
  bit                       shadow_overflow = 1'b0;

  int unsigned total_items    = 0;
  int unsigned accepted_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_pause       = 0;
  int unsigned rx_pause       = 0;
  bit          quiet_phase    = 1'b0;
  logic        hold_off       = 1'b0;
  sorted_item_t due;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("error at %0t: %s", $realtime, what);
  endtask

  // insert one accepted sample; on end of set, release the whole store in order
  function automatic void sort_insert(input logic signed [ValueW-1:0] v, input logic last);
    int pos;
    if (shadow_count >= SortDepth) begin
      // store full: the sample is dropped and the set is flagged
      shadow_overflow = 1'b1;
    end else begin
      pos = shadow_count;
      // strict less-than keeps equal values in arrival order
      while (pos > 0 && v < shadow_store[pos-1]) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = v;
      shadow_count++;
    end
    if (last) begin
      for (int i = 0; i < shadow_count; i++) begin
        sorted_due.push_back('{shadow_store[i], (i + 1 == shadow_count), shadow_overflow});
      end
      shadow_count    = 0;
      shadow_overflow = 1'b0;
    end
  endfunction

  function automatic void queue_sample(input logic signed [ValueW-1:0] v, input logic last);
    samples_pending.push_back('{v, last});
    total_items++;
  endfunction

  // random value: full range, a narrow band around zero for duplicates, or a corner value (min, max, zero, minus one)
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 3))
      1: pick_value = $signed($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: pick_value = MinValue;
          1: pick_value = MaxValue;
          2: pick_value = '0;
          default: pick_value = '1;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // driver: offers pending samples, idles in random bursts, holds a stalled payload
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      sample_value_i <= '0;
      end_of_set_i   <= 1'b0;
      tx_pause       <= 0;
    end else begin
      if (in_xfer) begin
        sort_insert(sample_value_i, end_of_set_i);
        accepted_items++;
      end
      quiet_phase <= (samples_pending.size() < QuietItems);
      if (in_valid_i && !in_xfer) begin
        // stalled: payload stays put
      end else if (tx_pause != 0) begin
        in_valid_i <= 1'b0;
        tx_pause   <= tx_pause - 1;
      end else if (samples_pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet_phase && !hold_off && $urandom_range(0, 4) == 0) begin
        // random idle burst
        in_valid_i <= 1'b0;
        tx_pause   <= $urandom_range(0, 5);
      end else begin
        in_valid_i     <= 1'b1;
        sample_value_i <= samples_pending[0].value;
        end_of_set_i   <= samples_pending[0].last;
        void'(samples_pending.pop_front());
      end
    end
  end

  // receiver stall: random bursts, plus the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_pause    <= 0;
    end else if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (rx_pause != 0) begin
      out_stall_i <= 1'b1;
      rx_pause    <= rx_pause - 1;
    end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      rx_pause    <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // long hold-off so the sorter fills up and stalls its input
  initial begin
    wait (accepted_items >= HoldOffAt);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffLen) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor: every result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_xfer) begin
      if (sorted_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", sorted_value_o));
      end else begin
        due = sorted_due.pop_front();
        if (sorted_value_o !== due.value) begin
          report_mismatch($sformatf("sorted_value %0d, want %0d", sorted_value_o, due.value));
        end
        if (final_result_o !== due.last) begin
          report_mismatch($sformatf("final_result %b, want %b", final_result_o, due.last));
        end
        if (overflowed_o !== due.ovf) begin
          report_mismatch($sformatf("overflowed %b, want %b", overflowed_o, due.ovf));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int set_len;
    int pick;

    // single-element set at the bottom of the range
    queue_sample(MinValue, 1'b1);

    // overflowing set: extremes, duplicates, mixed signs; the end-of-set item is dropped
    queue_sample(5, 1'b0);
    queue_sample(-5, 1'b0);
    queue_sample(MaxValue, 1'b0);
    queue_sample(MinValue, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(5, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(-2, 1'b0);
    queue_sample(MaxValue, 1'b0);
    queue_sample(MinValue, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(100, 1'b0);
    queue_sample(-100, 1'b0);
    queue_sample(7, 1'b0);
    queue_sample(3, 1'b0);
    queue_sample(42, 1'b1);

    // descending arrival, every insert goes to the head
    queue_sample(3, 1'b0);
    queue_sample(2, 1'b0);
    queue_sample(1, 1'b1);

    // random sets: mostly short, some exactly full, some overflowing
    while (total_items < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        set_len = $urandom_range(1, 8);
      end else if (pick <= 7) begin
        set_len = $urandom_range(9, SortDepth);
      end else if (pick == 8) begin
        set_len = SortDepth;
      end else begin
        set_len = $urandom_range(SortDepth + 1, SortDepth + 6);
      end
      for (int k = 0; k < set_len; k++) begin
        queue_sample(pick_value(), (k == set_len - 1));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items != total_items) @(posedge clk_i);
    while (sorted_due.size() != 0) @(posedge clk_i);
    // catch any stray results after the last set
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
